@@ src/lwt_pkg.sv @@
package lwt_pkg;

  // Field and matrix widths
  localparam int unsigned CoordBits = 32;
  localparam int unsigned EntryBits = 21;
  localparam int unsigned CfgBits   = 63;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned RowBits   = 3 * EntryBits;

  // Fixed-point fraction widths
  localparam int unsigned PosFrac   = 16;
  localparam int unsigned RecipFrac = EntryBits - 2;
  localparam int unsigned LatFrac   = EntryBits - 11;
  localparam int unsigned FractBits = PosFrac + RecipFrac;
  localparam int unsigned OutShift  = RecipFrac + LatFrac;

  // Datapath widths
  localparam int unsigned ProdBits    = CoordBits + EntryBits;
  localparam int unsigned SumBits     = ProdBits + 2;
  localparam int unsigned LoBits      = SumBits / 2;
  localparam int unsigned HiBits      = SumBits - LoBits;
  localparam int unsigned PpBits      = HiBits + EntryBits + 1;
  localparam int unsigned LatProdBits = SumBits + EntryBits;
  localparam int unsigned OutSumBits  = LatProdBits + 2;
  localparam int unsigned ShBits      = OutSumBits - OutShift;

  // Pipeline depth, accept to result strobe
  localparam int unsigned NumStages = 7;

  // Register indexes
  localparam logic [CfgIdxBits-1:0] RegLatRow0   = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegLatRow1   = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegLatRow2   = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegRecipRow0 = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegRecipRow1 = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegRecipRow2 = 3'd5;
  localparam logic [CfgIdxBits-1:0] RegMode      = 3'd6;

  typedef logic signed [CoordBits-1:0]   coord_t;
  typedef logic signed [EntryBits-1:0]   entry_t;
  typedef logic        [RowBits-1:0]     row_t;
  typedef logic signed [ProdBits-1:0]    prod_t;
  typedef logic signed [SumBits-1:0]     fsum_t;
  typedef logic signed [PpBits-1:0]      pp_t;
  typedef logic signed [LatProdBits-1:0] lprod_t;
  typedef logic signed [OutSumBits-1:0]  osum_t;

endpackage

@@ src/lattice_wrap_transform.sv @@
// Channel   | Direction | Ports                                   | Beat
// ----------+-----------+-----------------------------------------+-----------------------------
// command   | in        | start, busy, pos_x_i, pos_y_i, pos_z_i  | start high while busy low
// result    | out       | out_valid_o, new_x_o, new_y_o, new_z_o  | one cycle with out_valid_o
// config    | in        | cfg_valid_i, cfg_ready_o, cfg_index_i,  | cfg_valid_i and cfg_ready_o
//           |           | cfg_data_i                              |
//
// One position enters every cycle while busy is low; its result strobe comes up once the
// beat has passed through every stage register below.
// The depth is set by the two matrix products: reciprocal multiply, row sum, wrap, split
// lattice multiply (two partial products per entry), partial recombine, row sum, and the
// floor shift with saturation into the output register.
// busy is high only during reset and the first cycle after it; config is always ready.
// The receiver cannot stall, so every stage advances each cycle and valid bits ride along.
// Config writes are expected only while no beat is in flight.
module lattice_wrap_transform (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [lwt_pkg::CoordBits-1:0] pos_x_i,
  input  logic signed [lwt_pkg::CoordBits-1:0] pos_y_i,
  input  logic signed [lwt_pkg::CoordBits-1:0] pos_z_i,
  output logic                              out_valid_o,
  output logic signed [lwt_pkg::CoordBits-1:0] new_x_o,
  output logic signed [lwt_pkg::CoordBits-1:0] new_y_o,
  output logic signed [lwt_pkg::CoordBits-1:0] new_z_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lwt_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [lwt_pkg::CfgBits-1:0]       cfg_data_i
);

  localparam int unsigned FB = lwt_pkg::FractBits;
  // one half and one in the fractional format
  localparam logic [FB-1:0] Half = {1'b1, {(FB-1){1'b0}}};
  localparam logic [FB:0]   One  = {1'b1, {FB{1'b0}}};
  localparam logic [lwt_pkg::CoordBits-1:0] MaxCoord = {1'b0, {(lwt_pkg::CoordBits-1){1'b1}}};
  localparam logic [lwt_pkg::CoordBits-1:0] MinCoord = {1'b1, {(lwt_pkg::CoordBits-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  lwt_pkg::row_t lat_q   [3];
  lwt_pkg::row_t recip_q [3];
  logic          mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        lat_q[i]   <= '0;
        recip_q[i] <= '0;
      end
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        lwt_pkg::RegLatRow0:   lat_q[0]   <= cfg_data_i[lwt_pkg::RowBits-1:0];
        lwt_pkg::RegLatRow1:   lat_q[1]   <= cfg_data_i[lwt_pkg::RowBits-1:0];
        lwt_pkg::RegLatRow2:   lat_q[2]   <= cfg_data_i[lwt_pkg::RowBits-1:0];
        lwt_pkg::RegRecipRow0: recip_q[0] <= cfg_data_i[lwt_pkg::RowBits-1:0];
        lwt_pkg::RegRecipRow1: recip_q[1] <= cfg_data_i[lwt_pkg::RowBits-1:0];
        lwt_pkg::RegRecipRow2: recip_q[2] <= cfg_data_i[lwt_pkg::RowBits-1:0];
        lwt_pkg::RegMode:      mode_q     <= cfg_data_i[0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Unpack matrix entries; entry c of a row sits at bit c*EntryBits.
  lwt_pkg::entry_t lat_e   [3][3];
  lwt_pkg::entry_t recip_e [3][3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign lat_e[r][c]   = lat_q[r][c*lwt_pkg::EntryBits +: lwt_pkg::EntryBits];
      assign recip_e[r][c] = recip_q[r][c*lwt_pkg::EntryBits +: lwt_pkg::EntryBits];
    end
  end

  // ---------------------------------------------------------------------------
  // Command handshake and valid pipeline
  // ---------------------------------------------------------------------------
  logic busy_q;
  logic accept;
  logic [lwt_pkg::NumStages-1:0] valid_q;
  logic [lwt_pkg::NumStages-1:0] valid_d;

  // hold busy for the reset cycle only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy    = busy_q;
  assign accept  = start && !busy_q;
  assign valid_d = {valid_q[lwt_pkg::NumStages-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: reciprocal products, p_c * R[r][c]
  // ---------------------------------------------------------------------------
  lwt_pkg::coord_t pos [3];
  lwt_pkg::prod_t  prod1_d [3][3];
  lwt_pkg::prod_t  prod1_q [3][3];

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod1_d[r][c] = pos[c] * recip_e[r][c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d[0]) begin
      prod1_q <= prod1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: fractional coordinate, exact row sum
  // ---------------------------------------------------------------------------
  lwt_pkg::fsum_t acc_d [3];
  lwt_pkg::fsum_t acc_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_d[r] = lwt_pkg::SumBits'(prod1_q[r][0]) + lwt_pkg::SumBits'(prod1_q[r][1])
               + lwt_pkg::SumBits'(prod1_q[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d[1]) begin
      acc_q <= acc_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: wrap into the centered cell, or pass the sum through when mode is set.
  // Truncating toward zero then folding at one half reduces to a test on the
  // two's complement low bits: subtract one when they exceed one half, or
  // equal it for a non-negative sum. Exact halves flip sign that way.
  // ---------------------------------------------------------------------------
  lwt_pkg::fsum_t f_d [3];
  lwt_pkg::fsum_t f_q [3];

  always_comb begin
    logic [FB-1:0]    low;
    logic             neg;
    logic             up;
    logic signed [FB:0] wrapped;
    for (int r = 0; r < 3; r++) begin
      low     = acc_q[r][FB-1:0];
      neg     = acc_q[r][lwt_pkg::SumBits-1];
      up      = (low > Half) || ((low == Half) && !neg);
      wrapped = up ? ({1'b0, low} - One) : {1'b0, low};
      f_d[r]  = mode_q ? acc_q[r] : lwt_pkg::SumBits'(wrapped);
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d[2]) begin
      f_q <= f_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: lattice partial products, f split into low and high halves
  // ---------------------------------------------------------------------------
  lwt_pkg::pp_t plo_d [3][3];
  lwt_pkg::pp_t phi_d [3][3];
  lwt_pkg::pp_t plo_q [3][3];
  lwt_pkg::pp_t phi_q [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        plo_d[r][c] = $signed({1'b0, f_q[c][lwt_pkg::LoBits-1:0]}) * lat_e[r][c];
        phi_d[r][c] = $signed(f_q[c][lwt_pkg::SumBits-1:lwt_pkg::LoBits]) * lat_e[r][c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d[3]) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: recombine partials into full products L[r][c] * f_c
  // ---------------------------------------------------------------------------
  lwt_pkg::lprod_t lprod_d [3][3];
  lwt_pkg::lprod_t lprod_q [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        lprod_d[r][c] = (lwt_pkg::LatProdBits'(phi_q[r][c]) <<< lwt_pkg::LoBits)
                      + lwt_pkg::LatProdBits'(plo_q[r][c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d[4]) begin
      lprod_q <= lprod_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: output row sums
  // ---------------------------------------------------------------------------
  lwt_pkg::osum_t osum_d [3];
  lwt_pkg::osum_t osum_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      osum_d[r] = lwt_pkg::OutSumBits'(lprod_q[r][0]) + lwt_pkg::OutSumBits'(lprod_q[r][1])
                + lwt_pkg::OutSumBits'(lprod_q[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d[5]) begin
      osum_q <= osum_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: floor shift to Q16.16 (drop low bits) and saturate
  // ---------------------------------------------------------------------------
  logic [lwt_pkg::CoordBits-1:0] new_d [3];
  logic [lwt_pkg::CoordBits-1:0] new_q [3];

  always_comb begin
    logic [lwt_pkg::ShBits-1:0]                     sh;
    logic [lwt_pkg::ShBits-lwt_pkg::CoordBits:0]    top;
    for (int r = 0; r < 3; r++) begin
      sh  = osum_q[r][lwt_pkg::OutSumBits-1:lwt_pkg::OutShift];
      top = sh[lwt_pkg::ShBits-1:lwt_pkg::CoordBits-1];
      if ((&top) || !(|top)) begin
        new_d[r] = sh[lwt_pkg::CoordBits-1:0];
      end else if (sh[lwt_pkg::ShBits-1]) begin
        new_d[r] = MinCoord;
      end else begin
        new_d[r] = MaxCoord;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d[6]) begin
      new_q <= new_d;
    end
  end

  assign out_valid_o = valid_q[lwt_pkg::NumStages-1];
  assign new_x_o     = new_q[0];
  assign new_y_o     = new_q[1];
  assign new_z_o     = new_q[2];

`ifndef SYNTHESIS
  // every accepted beat strobes a fixed depth later
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(lwt_pkg::NumStages) out_valid_o)
    else $error("accepted beat did not strobe a result");

  // every strobe belongs to a beat accepted a fixed depth earlier
  a_no_stray : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(accept, lwt_pkg::NumStages))
    else $error("result strobe does not match accepted beat");

  // wrapped fractional coordinates stay sign-extended above the fraction bits, from minus one to below one
  a_wrap_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[2] && !mode_q) |->
      ((&f_q[0][lwt_pkg::SumBits-1:FB]) || !(|f_q[0][lwt_pkg::SumBits-1:FB])) &&
      ((&f_q[1][lwt_pkg::SumBits-1:FB]) || !(|f_q[1][lwt_pkg::SumBits-1:FB])) &&
      ((&f_q[2][lwt_pkg::SumBits-1:FB]) || !(|f_q[2][lwt_pkg::SumBits-1:FB])))
    else $error("wrapped coordinate out of the centered cell");

  // the first stage valid bit is clear at reset release
  a_busy_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !valid_q[0])
    else $error("beat accepted during reset release");
`endif

endmodule
